### rtl/core/strmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strmq_pkg
// Shared types, codes and helpers of the sparse-table range-maximum engine.
// ----------------------------------------------------------------------------
package strmq_pkg;

    localparam int DATA_W = 32;  // element word
    localparam int IDX_W  = 10;  // range index fields
    localparam int LEN_W  = 11;  // inclusive range length, up to 1024
    localparam int LOG_W  = 4;   // floor log2 of a range length
    localparam int CNT_W  = 11;  // element count field

    // Opcodes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]        range_start;
        logic [IDX_W-1:0]        range_end;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] max_value;
        logic [1:0]              status;
        logic [CNT_W-1:0]        element_count;
    } t_out;

    // Data handed from one level cell to the next during an append
    typedef struct packed {
        logic                    token;    // append wave passes this cell
        logic                    write;    // previous level wrote an entry
        logic signed [DATA_W-1:0] new_val; // entry just written by previous level
        logic signed [DATA_W-1:0] old_val; // older previous-level entry (RAM read)
    } t_link;

    function automatic logic signed [DATA_W-1:0] max_signed(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return (a >= b) ? a : b;
    endfunction

endpackage

### rtl/core/strmq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strmq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module strmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/strmq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strmq_cell
// One sparse-table level: owns the level RAM, fills the entry that an append
// completes, and reads the older entry that the next level needs.
// ----------------------------------------------------------------------------
module strmq_cell
    import strmq_pkg::*;
#(
    parameter int LEVEL = 0,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [CW-1:0] i_count,
    input  t_link         i_link,
    input  logic          i_qsel,
    input  logic [AW-1:0] i_qaddr,
    output t_link         o_link
);

    localparam int PW = (CW > LEVEL + 2) ? CW + 1 : LEVEL + 2;

    logic [PW-1:0]            w_n1;
    logic [PW-1:0]            w_wpos;
    logic [PW-1:0]            w_rpos;
    logic                     w_fits;
    logic                     w_we;
    logic signed [DATA_W-1:0] w_wdata;
    logic [AW-1:0]            w_raddr;
    logic [DATA_W-1:0]        w_rdata;

    logic                     r_token;
    logic                     r_write;
    logic signed [DATA_W-1:0] r_new_val;

    // Entry positions: this level completes n+1-2^L, next level needs n+1-2^(L+1)
    always_comb begin
        w_n1   = PW'(i_count) + PW'(1);
        w_fits = w_n1 >= (PW'(1) << LEVEL);
        w_wpos = w_n1 - (PW'(1) << LEVEL);
        w_rpos = w_n1 - (PW'(1) << (LEVEL + 1));
        w_we   = i_link.write && w_fits;
        w_raddr = i_qsel ? i_qaddr : w_rpos[AW-1:0];
    end

    // Level zero stores the element, higher levels combine two halves
    generate
        if (LEVEL == 0) begin : g_base
            assign w_wdata = i_link.new_val;
        end else begin : g_merge
            assign w_wdata = max_signed(i_link.old_val, i_link.new_val);
        end
    endgenerate

    strmq_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_wpos[AW-1:0]),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Advance the append wave to the next level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token <= 1'b0;
            r_write <= 1'b0;
        end else begin
            r_token <= i_link.token;
            r_write <= w_we;
        end
    end

    // Hold the value just written for the neighbor
    always_ff @(posedge i_clk) begin
        r_new_val <= w_wdata;
    end

    assign o_link = '{token: r_token, write: r_write, new_val: r_new_val,
                      old_val: w_rdata};

endmodule

### rtl/core/sparse_table_range_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_table_range_max
// Range-maximum engine over an incrementally built sparse table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one transaction
//   per item: clear, append or query. Output channel (o_out_valid /
//   i_out_ready / o_out_data) returns exactly one result per item, in order.
//   Items are processed one at a time. Path from accept to result valid:
//     clear, unused opcode, full append, bad range: straight to the result
//     append: the append wave walks the chain of
//             level cells, one level RAM per cycle
//     query:  two reads of the level RAM through its single read port
//   The next item is accepted once the previous one has moved into the output
//   register, even while that result waits; a stalled receiver holds the
//   result and blocks only the item after the held one.
//   Reset clears the element count and the handshake state; the level RAMs
//   are not cleared and need no clearing pass, since only entries below the
//   count are ever read.
// ----------------------------------------------------------------------------
module sparse_table_range_max
    import strmq_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024,
    parameter int NUM_LEVELS   = 11
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int KW = $clog2(NUM_LEVELS);
    localparam int XW = (CW > LEN_W) ? CW : LEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_QRD_A,
        S_QRD_B,
        S_QCAP,
        S_EMIT
    } t_state;

    t_state                   r_state;
    logic [CW-1:0]            r_count;
    t_link                    r_link0;
    logic [AW-1:0]            r_from;
    logic [AW-1:0]            r_addr_b;
    logic [KW-1:0]            r_k;
    logic signed [DATA_W-1:0] r_val_a;
    logic signed [DATA_W-1:0] r_res;
    logic [1:0]               r_status;
    logic                     r_out_valid;
    t_out                     r_out;

    t_link                    w_link [NUM_LEVELS+1];
    logic signed [DATA_W-1:0] w_rd   [NUM_LEVELS];
    logic [NUM_LEVELS-1:0]    w_qsel;
    logic [AW-1:0]            w_qaddr;
    logic signed [DATA_W-1:0] w_sel_rd;

    logic [XW-1:0]            w_from_x;
    logic [XW-1:0]            w_to_x;
    logic [XW-1:0]            w_cnt_x;
    logic [XW-1:0]            w_bpos_x;
    logic [XW-1:0]            w_out_cnt_x;
    logic                     w_bad_range;
    logic                     w_full;
    logic [LEN_W-1:0]         w_len;
    logic [LOG_W-1:0]         w_log;
    logic [LOG_W-1:0]         w_kc;
    logic [LEN_W-1:0]         w_bpos;

    // Query decode: range check, level pick, second entry position
    always_comb begin
        w_from_x    = XW'(i_in_data.range_start);
        w_to_x      = XW'(i_in_data.range_end);
        w_cnt_x     = XW'(r_count);
        w_bad_range = (w_from_x > w_to_x) || (w_to_x >= w_cnt_x);
        w_full      = r_count >= CW'(MAX_ELEMENTS);
        w_len       = LEN_W'(i_in_data.range_end) - LEN_W'(i_in_data.range_start)
                      + LEN_W'(1);
        w_log       = '0;
        for (int i = 0; i < LEN_W; i++) begin
            if (w_len[i]) begin
                w_log = LOG_W'(i);
            end
        end
        w_kc     = (32'(w_log) >= NUM_LEVELS) ? LOG_W'(NUM_LEVELS - 1) : w_log;
        w_bpos   = LEN_W'(i_in_data.range_end) + LEN_W'(1) - (LEN_W'(1) << w_kc);
        w_bpos_x = XW'(w_bpos);
    end

    // Level select and address for query reads
    always_comb begin
        for (int j = 0; j < NUM_LEVELS; j++) begin
            w_qsel[j] = ((r_state == S_QRD_A) || (r_state == S_QRD_B)) &&
                        (r_k == KW'(j));
        end
        w_qaddr  = (r_state == S_QRD_A) ? r_from : r_addr_b;
        w_sel_rd = w_rd[r_k];
    end

    // Chain of level cells
    assign w_link[0] = r_link0;

    generate
        for (genvar j = 0; j < NUM_LEVELS; j++) begin : g_cell
            strmq_cell #(
                .LEVEL(j),
                .DEPTH(MAX_ELEMENTS)
            ) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_count(r_count),
                .i_link (w_link[j]),
                .i_qsel (w_qsel[j]),
                .i_qaddr(w_qaddr),
                .o_link (w_link[j+1])
            );
            assign w_rd[j] = w_link[j+1].old_val;
        end
    endgenerate

    assign w_out_cnt_x = XW'(r_count);

    // Sequencer: hold state, count and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_link0.token <= 1'b0;
            r_link0.write <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_link0.token <= 1'b0;
            r_link0.write <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_res    <= '0;
                        r_status <= ST_OK;
                        r_state  <= S_EMIT;
                        case (i_in_data.opcode)
                            OP_CLEAR: begin
                                r_count <= '0;
                            end
                            OP_APPEND: begin
                                if (w_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_link0 <= '{token: 1'b1, write: 1'b1,
                                                 new_val: i_in_data.value,
                                                 old_val: '0};
                                    r_state <= S_APPEND;
                                end
                            end
                            OP_QUERY: begin
                                if (w_bad_range) begin
                                    r_status <= ST_RANGE;
                                end else begin
                                    r_from   <= w_from_x[AW-1:0];
                                    r_addr_b <= w_bpos_x[AW-1:0];
                                    r_k      <= KW'(w_kc);
                                    r_state  <= S_QRD_A;
                                end
                            end
                            default: begin
                                r_status <= ST_OK;
                            end
                        endcase
                    end
                end
                S_APPEND: begin
                    // wave left the top level: every entry is written
                    if (w_link[NUM_LEVELS].token) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_EMIT;
                    end
                end
                S_QRD_A: begin
                    r_state <= S_QRD_B;
                end
                S_QRD_B: begin
                    r_val_a <= w_sel_rd;
                    r_state <= S_QCAP;
                end
                S_QCAP: begin
                    r_res   <= max_signed(r_val_a, w_sel_rd);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid         <= 1'b1;
                        r_out.max_value     <= r_res;
                        r_out.status        <= r_status;
                        r_out.element_count <= w_out_cnt_x[CNT_W-1:0];
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
